// ----- rtl/assert_macros.svh -----
// assertion helpers included by the span converter rtl
// every macro samples on i_clk and is disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every sampled edge
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/crsc_pkg.sv -----
// ----------------------------------------------------------------------------
// crsc_pkg
// shared constants and types of the column to row span converter
// ----------------------------------------------------------------------------
`default_nettype none

package crsc_pkg;

    // row store geometry
    localparam int ROWS     = 64;
    localparam int COLS     = 1024;
    localparam int ROW_W    = 6;
    localparam int COL_W    = $clog2(COLS);
    localparam int X_W      = 11;

    // loop cursors carry one extra bit for the "below every row" marker
    localparam int CUR_W    = ROW_W + 1;
    localparam logic [CUR_W-1:0] CUR_EMPTY = {CUR_W{1'b1}};

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CLOSE_T = 7'b0000010,
        S_CLOSE_B = 7'b0000100,
        S_FETCH   = 7'b0001000,
        S_FLUSH   = 7'b0010000,
        S_OPEN_T  = 7'b0100000,
        S_OPEN_B  = 7'b1000000
    } t_state;

    // operand selection of the shared step unit
    typedef enum logic [1:0] {
        PH_CLOSE_TOP = 2'd0,
        PH_CLOSE_BOT = 2'd1,
        PH_OPEN_TOP  = 2'd2,
        PH_OPEN_BOT  = 2'd3
    } t_phase;

endpackage

`default_nettype wire

// ----- rtl/crsc_ram.sv -----
// ----------------------------------------------------------------------------
// crsc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module crsc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/column_to_row_span_converter.sv -----
// ----------------------------------------------------------------------------
// column_to_row_span_converter
// turns per-column vertical extents of a plane into horizontal row spans
// ----------------------------------------------------------------------------
// Usage: columns of a plane enter left to right on the slave stream, one per
// request; tuser flags an empty column and the first column of a plane, and
// an empty column at maxx+1 flushes every open row. Each row closed by a
// column leaves on the master stream as (row, left, right) with tlast on the
// final span caused by that column; a column that closes nothing sends none.
// Timing: one shared compare and step unit walks the four row loops. A
// closed row is read from the row store, then handed off in the fetch
// state, which stalls while the output and hold registers are full; the
// opening loops write one row start per cycle. o_s_tready is high only
// between columns.
// Stalls: one span waits in the output register and one in a hold register;
// when both are full the sequencer stops until the receiver takes a span.
// Reset: synchronous, active low; the previous column counts as empty and the
// row start store is not cleared (a start is written before it is read).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module column_to_row_span_converter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // column requests
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // column_x[10:0], column_top[16:11], column_bottom[22:17], zero[23]
    input  wire logic [crsc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // column_empty[0], plane_first[1]
    input  wire logic [crsc_pkg::S_TUSER_W-1:0] i_s_tuser,
    // span results
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // span_row[5:0], span_left[15:6], span_right[25:16], zero[31:26]
    output logic      [crsc_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                                o_m_tlast
);

    localparam int RW = crsc_pkg::ROW_W;
    localparam int CW = crsc_pkg::COL_W;
    localparam int UW = crsc_pkg::CUR_W;

    // control state
    crsc_pkg::t_state r_state, n_state;
    logic             r_prev_empty, n_prev_empty;
    logic [RW-1:0]    r_prev_top, n_prev_top;
    logic [RW-1:0]    r_prev_bot, n_prev_bot;
    logic             r_hold_valid, n_hold_valid;
    logic             r_out_valid, n_out_valid;
    logic             r_from_bot, n_from_bot;

    // per-column payload
    logic [UW-1:0]    r_t1, n_t1, r_b1, n_b1, r_t2, n_t2, r_b2, n_b2;
    logic [CW-1:0]    r_x, n_x;
    logic [CW-1:0]    r_right, n_right;
    logic [RW-1:0]    r_fetch_row, n_fetch_row;
    logic [RW-1:0]    r_hold_row, n_hold_row;
    logic [CW-1:0]    r_hold_left, n_hold_left;
    logic [RW-1:0]    r_out_row, n_out_row;
    logic [CW-1:0]    r_out_left, n_out_left;
    logic [CW-1:0]    r_out_right, n_out_right;
    logic             r_out_last, n_out_last;

    // row store port
    logic             ram_we, ram_re;
    logic [RW-1:0]    ram_waddr, ram_raddr;
    logic [CW-1:0]    ram_rdata;

    // shared step unit
    crsc_pkg::t_phase phase;
    logic [UW-1:0]    op_p, op_q, op_r, op_s, cur, cur_step;
    logic             step_up, step_go;

    logic             in_req, out_free;

    assign in_req   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // row start store
    crsc_ram #(
        .WIDTH (CW),
        .DEPTH (crsc_pkg::ROWS)
    ) u_row_start (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_x),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // loop selection from the sequencer state
    always_comb begin
        unique case (r_state)
            crsc_pkg::S_CLOSE_B: phase = crsc_pkg::PH_CLOSE_BOT;
            crsc_pkg::S_OPEN_T:  phase = crsc_pkg::PH_OPEN_TOP;
            crsc_pkg::S_OPEN_B:  phase = crsc_pkg::PH_OPEN_BOT;
            default:             phase = crsc_pkg::PH_CLOSE_TOP;
        endcase
    end

    // operand mux: every loop runs while p < q and r <= s
    always_comb begin
        unique case (phase)
            crsc_pkg::PH_CLOSE_TOP: begin
                op_p = r_t1; op_q = r_t2; op_r = r_t1; op_s = r_b1;
                cur = r_t1; step_up = 1'b1;
            end
            crsc_pkg::PH_CLOSE_BOT: begin
                op_p = r_b2; op_q = r_b1; op_r = r_t1; op_s = r_b1;
                cur = r_b1; step_up = 1'b0;
            end
            crsc_pkg::PH_OPEN_TOP: begin
                op_p = r_t2; op_q = r_t1; op_r = r_t2; op_s = r_b2;
                cur = r_t2; step_up = 1'b1;
            end
            default: begin
                op_p = r_b1; op_q = r_b2; op_r = r_t2; op_s = r_b2;
                cur = r_b2; step_up = 1'b0;
            end
        endcase
    end

    assign step_go  = (op_p < op_q) && (op_r <= op_s);
    assign cur_step = step_up ? cur + UW'(1) : cur - UW'(1);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_prev_empty = r_prev_empty;
        n_prev_top   = r_prev_top;
        n_prev_bot   = r_prev_bot;
        n_hold_valid = r_hold_valid;
        n_out_valid  = r_out_valid;
        n_from_bot   = r_from_bot;
        n_t1         = r_t1;
        n_b1         = r_b1;
        n_t2         = r_t2;
        n_b2         = r_b2;
        n_x          = r_x;
        n_right      = r_right;
        n_fetch_row  = r_fetch_row;
        n_hold_row   = r_hold_row;
        n_hold_left  = r_hold_left;
        n_out_row    = r_out_row;
        n_out_left   = r_out_left;
        n_out_right  = r_out_right;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = cur[RW-1:0];
        ram_raddr    = cur[RW-1:0];

        // output register drains
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            crsc_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_t1 = (r_prev_empty || i_s_tuser[1]) ? crsc_pkg::CUR_EMPTY
                                                          : {1'b0, r_prev_top};
                    n_b1 = {1'b0, r_prev_bot};
                    n_t2 = i_s_tuser[0] ? crsc_pkg::CUR_EMPTY : {1'b0, i_s_tdata[16:11]};
                    n_b2 = {1'b0, i_s_tdata[22:17]};
                    n_x          = i_s_tdata[CW-1:0];
                    n_right      = i_s_tdata[CW-1:0] - CW'(1);
                    n_prev_top   = i_s_tdata[16:11];
                    n_prev_bot   = i_s_tdata[22:17];
                    n_prev_empty = i_s_tuser[0];
                    n_state      = crsc_pkg::S_CLOSE_T;
                end
            end
            crsc_pkg::S_CLOSE_T, crsc_pkg::S_CLOSE_B: begin
                if (step_go) begin
                    ram_re      = 1'b1;
                    n_fetch_row = cur[RW-1:0];
                    n_from_bot  = (r_state == crsc_pkg::S_CLOSE_B);
                    n_state     = crsc_pkg::S_FETCH;
                    if (r_state == crsc_pkg::S_CLOSE_B) begin
                        n_b1 = cur_step;
                    end else begin
                        n_t1 = cur_step;
                    end
                end else begin
                    n_state = (r_state == crsc_pkg::S_CLOSE_B) ? crsc_pkg::S_FLUSH
                                                               : crsc_pkg::S_CLOSE_B;
                end
            end
            crsc_pkg::S_FETCH: begin
                // the held span is not last: another one follows it
                if (!r_hold_valid || out_free) begin
                    if (r_hold_valid) begin
                        n_out_valid = 1'b1;
                        n_out_row   = r_hold_row;
                        n_out_left  = r_hold_left;
                        n_out_right = r_right;
                        n_out_last  = 1'b0;
                    end
                    n_hold_valid = 1'b1;
                    n_hold_row   = r_fetch_row;
                    n_hold_left  = ram_rdata;
                    n_state      = r_from_bot ? crsc_pkg::S_CLOSE_B : crsc_pkg::S_CLOSE_T;
                end
            end
            crsc_pkg::S_FLUSH: begin
                // closing is done, the held span ends the column
                if (!r_hold_valid) begin
                    n_state = crsc_pkg::S_OPEN_T;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_row    = r_hold_row;
                    n_out_left   = r_hold_left;
                    n_out_right  = r_right;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = crsc_pkg::S_OPEN_T;
                end
            end
            crsc_pkg::S_OPEN_T, crsc_pkg::S_OPEN_B: begin
                if (step_go) begin
                    ram_we = 1'b1;
                    if (r_state == crsc_pkg::S_OPEN_B) begin
                        n_b2 = cur_step;
                    end else begin
                        n_t2 = cur_step;
                    end
                end else begin
                    n_state = (r_state == crsc_pkg::S_OPEN_B) ? crsc_pkg::S_IDLE
                                                              : crsc_pkg::S_OPEN_B;
                end
            end
            default: begin
                n_state = crsc_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= crsc_pkg::S_IDLE;
            r_prev_empty <= 1'b1;
            r_prev_top   <= '0;
            r_prev_bot   <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_from_bot   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_empty <= n_prev_empty;
            r_prev_top   <= n_prev_top;
            r_prev_bot   <= n_prev_bot;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            r_from_bot   <= n_from_bot;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_t1        <= n_t1;
        r_b1        <= n_b1;
        r_t2        <= n_t2;
        r_b2        <= n_b2;
        r_x         <= n_x;
        r_right     <= n_right;
        r_fetch_row <= n_fetch_row;
        r_hold_row  <= n_hold_row;
        r_hold_left <= n_hold_left;
        r_out_row   <= n_out_row;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
        r_out_last  <= n_out_last;
    end

    // ports
    assign o_s_tready = (r_state == crsc_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {(crsc_pkg::M_TDATA_W - RW - 2 * CW)'(0),
                         r_out_right, r_out_left, r_out_row};

    // store is never read and written in one cycle
    `ASSERT_IMPLIES(a_port_exclusive, ram_we, !ram_re)
    // a new column starts closing with an empty hold stage
    `ASSERT_NEXT(a_start_clean, in_req,
                 (r_state == crsc_pkg::S_CLOSE_T) && !r_hold_valid)
    // opening only runs after the last span left the hold stage
    `ASSERT_IMPLIES(a_open_flushed,
                    (r_state == crsc_pkg::S_OPEN_T) || (r_state == crsc_pkg::S_OPEN_B),
                    !r_hold_valid)
    // between columns only a final span can still wait
    `ASSERT_IMPLIES(a_idle_last, (r_state == crsc_pkg::S_IDLE) && r_out_valid, r_out_last)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the column to row span converter
// ----------------------------------------------------------------------------
// Columns go in on the slave stream, first from a short table of hand-picked
// cases, then as random planes of walking extents, each closed by an empty
// flush column, mixed with some noise columns. A behavioral predictor keeps
// its own copy of the previous extent and the per-row start columns and
// queues the spans each column must close; every span taken from the master
// stream is checked field by field against the oldest queued span. Both
// streams stall at random in the first two of three phases, the last runs free.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int CLK_HALF       = 6;
    localparam int RANDOM_COLUMNS = 280;
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_NS     = 10_000_000;
    localparam int BELOW_ROWS     = crsc_pkg::ROWS;
    localparam int LAST_ROW       = crsc_pkg::ROWS - 1;
    localparam int N_DIRECTED     = 21;
    localparam int TOTAL_COLUMNS  = N_DIRECTED + RANDOM_COLUMNS;

    // one column request
    typedef struct packed {
        logic [10:0] col_x;
        logic [5:0]  top_row;
        logic [5:0]  bottom_row;
        logic        is_empty;
        logic        plane_first;
    } column_t;

    // one closed row span
    typedef struct packed {
        logic [5:0] span_row;
        logic [9:0] span_left;
        logic [9:0] span_right;
        logic       span_last;
    } span_t;

    // how the spans of a table row are obtained
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_SPAN,
        ONE_SPAN
    } check_kind_t;

    typedef struct packed {
        column_t     column;
        check_kind_t kind;
        span_t       typed;
    } directed_row_t;

    // hand-picked columns; typed spans where the answer is obvious
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // full-height first column at x zero, opens every row
        '{'{11'd0,    6'd0,  6'd63, 1'b0, 1'b1}, NO_SPAN,  '0},
        '{'{11'd1,    6'd1,  6'd63, 1'b0, 1'b0}, ONE_SPAN, '{6'd0,  10'd0,    10'd0,    1'b1}},
        '{'{11'd2,    6'd1,  6'd62, 1'b0, 1'b0}, ONE_SPAN, '{6'd63, 10'd0,    10'd1,    1'b1}},
        // empty column with all-ones extent bits closes the rest
        '{'{11'd3,    6'd63, 6'd63, 1'b1, 1'b0}, BY_MODEL, '0},
        // starts at 1023, then columns 1024 and zero wrap the right edge
        '{'{11'd1023, 6'd5,  6'd10, 1'b0, 1'b1}, NO_SPAN,  '0},
        '{'{11'd1024, 6'd6,  6'd10, 1'b0, 1'b0}, ONE_SPAN, '{6'd5,  10'd1023, 10'd1023, 1'b1}},
        '{'{11'd0,    6'd6,  6'd9,  1'b0, 1'b0}, ONE_SPAN, '{6'd10, 10'd1023, 10'd1023, 1'b1}},
        // inverted extent closes the old rows and opens none
        '{'{11'd5,    6'd40, 6'd3,  1'b0, 1'b0}, BY_MODEL, '0},
        '{'{11'd6,    6'd0,  6'd63, 1'b0, 1'b0}, NO_SPAN,  '0},
        // shrinking, shifting and growing extents
        '{'{11'd7,    6'd20, 6'd30, 1'b0, 1'b0}, BY_MODEL, '0},
        '{'{11'd8,    6'd25, 6'd35, 1'b0, 1'b0}, BY_MODEL, '0},
        '{'{11'd9,    6'd10, 6'd28, 1'b0, 1'b0}, BY_MODEL, '0},
        '{'{11'd10,   6'd0,  6'd0,  1'b1, 1'b0}, BY_MODEL, '0},
        // plane start drops the open row of the previous column
        '{'{11'd100,  6'd0,  6'd0,  1'b0, 1'b0}, NO_SPAN,  '0},
        '{'{11'd101,  6'd0,  6'd0,  1'b0, 1'b1}, NO_SPAN,  '0},
        '{'{11'd102,  6'd0,  6'd0,  1'b1, 1'b0}, ONE_SPAN, '{6'd0,  10'd101,  10'd101,  1'b1}},
        // bottom row alone
        '{'{11'd200,  6'd63, 6'd63, 1'b0, 1'b1}, NO_SPAN,  '0},
        '{'{11'd201,  6'd63, 6'd63, 1'b1, 1'b0}, ONE_SPAN, '{6'd63, 10'd200,  10'd200,  1'b1}},
        // empty first column, inverted first column, then a flush
        '{'{11'd1024, 6'd0,  6'd0,  1'b1, 1'b1}, NO_SPAN,  '0},
        '{'{11'd512,  6'd32, 6'd31, 1'b0, 1'b1}, NO_SPAN,  '0},
        '{'{11'd513,  6'd0,  6'd63, 1'b1, 1'b0}, NO_SPAN,  '0}
    };

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    // column_x, column_top, column_bottom, zero
    logic [crsc_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    // column_empty, plane_first
    logic [crsc_pkg::S_TUSER_W-1:0] i_s_tuser  = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    // span_row, span_left, span_right, zero
    logic [crsc_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                           o_m_tlast;

    // predictor state
    logic [5:0] prev_top    = '0;
    logic [5:0] prev_bottom = '0;
    logic       prev_empty  = 1'b1;
    logic [9:0] row_start [crsc_pkg::ROWS];
    bit         row_set   [crsc_pkg::ROWS];

    span_t pending_spans [$];
    int    error_count   = 0;
    int    columns_sent  = 0;
    int    src_idle_pct  = 25;
    int    snk_idle_pct  = 56;

    column_to_row_span_converter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // spans closed by one column, state updated as the block would
    function automatic void predict_spans(input column_t c, ref span_t spans[$]);
        int         t_old;
        int         b_old;
        int         t_new;
        int         b_new;
        logic [9:0] right_col;
        spans.delete();
        right_col = 10'(c.col_x - 11'd1);
        if (c.plane_first) prev_empty = 1'b1;
        t_old = prev_empty ? BELOW_ROWS : int'(prev_top);
        b_old = int'(prev_bottom);
        t_new = c.is_empty ? BELOW_ROWS : int'(c.top_row);
        b_new = int'(c.bottom_row);
        // close rows above the new top, going down
        while (t_old < t_new && t_old <= b_old) begin
            spans.push_back('{6'(t_old), row_start[t_old], right_col, 1'b0});
            t_old++;
        end
        // close rows below the new bottom, going up
        while (b_old > b_new && b_old >= t_old) begin
            spans.push_back('{6'(b_old), row_start[b_old], right_col, 1'b0});
            b_old--;
        end
        // record the start of newly covered rows
        while (t_new < t_old && t_new <= b_new) begin
            row_start[t_new] = c.col_x[9:0];
            row_set[t_new]   = 1'b1;
            t_new++;
        end
        while (b_new > b_old && b_new >= t_new) begin
            row_start[b_new] = c.col_x[9:0];
            row_set[b_new]   = 1'b1;
            b_new--;
        end
        if (spans.size() > 0) spans[spans.size() - 1].span_last = 1'b1;
        prev_top    = c.top_row;
        prev_bottom = c.bottom_row;
        prev_empty  = c.is_empty;
    endfunction

    // true when the column could close a row whose start was never recorded
    function automatic bit reads_unset_start(input column_t c);
        if (c.plane_first || prev_empty) return 1'b0;
        for (int r = int'(prev_top); r <= int'(prev_bottom); r++) begin
            if (!row_set[r]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int clamp_row(input int v);
        return (v < 0) ? 0 : ((v > LAST_ROW) ? LAST_ROW : v);
    endfunction

    // queue the expected spans, then hold the request until it is taken
    task automatic send_column(input column_t c, input check_kind_t kind, input span_t typed);
        span_t col_spans [$];
        // idling pattern by phase of the run
        if (columns_sent < TOTAL_COLUMNS / 3) begin
            src_idle_pct = 25;
            snk_idle_pct = 56;
        end else if (columns_sent < 2 * TOTAL_COLUMNS / 3) begin
            src_idle_pct = 56;
            snk_idle_pct = 25;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        predict_spans(c, col_spans);
        case (kind)
            BY_MODEL: begin
                foreach (col_spans[i]) pending_spans.push_back(col_spans[i]);
            end
            ONE_SPAN: begin
                pending_spans.push_back(typed);
            end
            default: begin
            end
        endcase
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, c.bottom_row, c.top_row, c.col_x};
        i_s_tuser  <= {c.plane_first, c.is_empty};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        columns_sent++;
    endtask

    // random planes of walking extents, each flushed, with noise columns between
    task automatic run_random_planes(input int n_columns);
        column_t c;
        int      target;
        int      len;
        int      start_x;
        int      top_r;
        int      bot_r;
        target = columns_sent + n_columns;
        while (columns_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise column
                c.col_x       = 11'($urandom_range(0, 1024));
                c.top_row     = 6'($urandom);
                c.bottom_row  = 6'($urandom);
                c.is_empty    = 1'($urandom);
                c.plane_first = 1'($urandom);
                if (reads_unset_start(c)) c.plane_first = 1'b1;
                send_column(c, BY_MODEL, '0);
            end else begin
                len     = $urandom_range(1, 20);
                start_x = $urandom_range(0, 1024 - len);
                top_r   = $urandom_range(0, LAST_ROW);
                bot_r   = $urandom_range(top_r, LAST_ROW);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 10) begin
                        // jump, possibly to an inverted extent
                        top_r = $urandom_range(0, LAST_ROW);
                        bot_r = $urandom_range(0, LAST_ROW);
                    end else begin
                        top_r = clamp_row(top_r + int'($urandom_range(0, 8)) - 4);
                        bot_r = clamp_row(bot_r + int'($urandom_range(0, 8)) - 4);
                        if (bot_r < top_r) bot_r = top_r;
                    end
                    c.col_x       = 11'(start_x + i);
                    c.top_row     = 6'(top_r);
                    c.bottom_row  = 6'(bot_r);
                    c.is_empty    = ($urandom_range(0, 99) < 8);
                    c.plane_first = (i == 0);
                    if (reads_unset_start(c)) c.plane_first = 1'b1;
                    send_column(c, BY_MODEL, '0);
                end
                // flush column just past the plane
                c.col_x       = 11'(start_x + len);
                c.top_row     = 6'($urandom);
                c.bottom_row  = 6'($urandom);
                c.is_empty    = 1'b1;
                c.plane_first = 1'b0;
                send_column(c, BY_MODEL, '0);
            end
        end
    endtask

    // span receiver and checker
    always @(posedge i_clk) begin
        span_t got;
        span_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[5:0], o_m_tdata[15:6], o_m_tdata[25:16], o_m_tlast};
            if (pending_spans.size() == 0) begin
                error_count++;
                $display("%0t: unexpected span row %0d left %0d right %0d last %0b",
                         $time, got.span_row, got.span_left, got.span_right, got.span_last);
            end else begin
                want = pending_spans.pop_front();
                if (got.span_row !== want.span_row || got.span_left !== want.span_left ||
                    got.span_right !== want.span_right || got.span_last !== want.span_last) begin
                    error_count++;
                    $display("%0t: span mismatch, expected row %0d left %0d right %0d last %0b",
                             $time, want.span_row, want.span_left, want.span_right,
                             want.span_last);
                    $display("%0t:                  actual row %0d left %0d right %0d last %0b",
                             $time, got.span_row, got.span_left, got.span_right, got.span_last);
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_column(DIRECTED_ROWS[i].column, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].typed);
        end
        run_random_planes(RANDOM_COLUMNS);
        i_s_tvalid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
